// ===== src/smp_pkg.sv =====
package smp_pkg;

  // Sizing of the matching engine.
  localparam int MAX_PARTIES = 16;
  localparam int IDX_W       = $clog2(MAX_PARTIES);
  localparam int POS_W       = IDX_W + 1;
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int MEM_DEPTH   = MAX_PARTIES * MAX_PARTIES;
  localparam int SIZE_W      = 5;
  localparam int CHOICE_W    = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_PARTIES);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_PARTIES);

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_LOAD_PROP = 2'd0;
  localparam logic [1:0] ACT_LOAD_ACC  = 2'd1;
  localparam logic [1:0] ACT_RUN       = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    position;
    logic [CHOICE_W-1:0] choice;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] acceptor;
    logic [IDX_W-1:0] partner;
    logic             matched;
    logic             last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_prop;
    logic wr_acc;
    logic clear;
    logic mark_done;
    logic propose;
    logic accept_free;
    logic read_ranks;
    logic replace;
    logic report;
    logic emit;
  } smp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic all_done;
    logic np_exhausted;
    logic s_beyond;
    logic s_taken;
    logic cur_is_h;
    logic new_wins;
    logic emit_last;
    logic out_free;
  } smp_status_t;

endpackage

// ===== src/smp_datapath.sv =====
module smp_datapath
  import smp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  smp_cmd_t          cmd,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              out_ready,
  output smp_status_t       status,
  output logic              out_valid,
  output out_item_t         out_data
);

  // Preference stores: proposer lists hold acceptor indexes, acceptor
  // ranks hold the place of each proposer in the acceptor's list.
  logic [IDX_W-1:0] plist_mem_r [MEM_DEPTH];
  logic [IDX_W-1:0] rank_mem_r  [MEM_DEPTH];
  logic [IDX_W-1:0] list_q_r;
  logic [IDX_W-1:0] rank_new_q_r;
  logic [IDX_W-1:0] rank_cur_q_r;

  // Matching state.
  logic [MAX_PARTIES-1:0] done_r;
  logic [MAX_PARTIES-1:0] has_r;
  logic [IDX_W-1:0]       partner_r [MAX_PARTIES];
  logic [POS_W-1:0]       np_r      [MAX_PARTIES];
  logic [IDX_W-1:0]       h_r;
  logic [IDX_W-1:0]       cur_r;
  logic [IDX_W-1:0]       a_r;
  logic [SIZE_W-1:0]      size_r;

  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [IDX_W-1:0]       who;
  logic [IDX_W-1:0]       n_m1;
  logic [IDX_W-1:0]       free_idx;
  logic [POS_W-1:0]       np_h;
  logic [IDX_W-1:0]       s;
  logic [IDX_W-1:0]       part_addr;
  logic [IDX_W-1:0]       part_q;

  // One-based choice to zero-based index, wrapping like the list width.
  assign who = IDX_W'(in_data.choice - CHOICE_W'(1));

  // Highest party index in use; zero is taken as one, oversize as the maximum.
  always_comb begin
    if (size_r == '0) begin
      n_m1 = '0;
    end else if (size_r > SIZE_MAX) begin
      n_m1 = IDX_W'(MAX_PARTIES - 1);
    end else begin
      n_m1 = IDX_W'(size_r - SIZE_W'(1));
    end
  end

  // Lowest-numbered free proposer.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_PARTIES - 1; i >= 0; i--) begin
      if (!done_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign np_h      = np_r[free_idx];
  assign s         = list_q_r;
  assign part_addr = cmd.report ? a_r : s;
  assign part_q    = partner_r[part_addr];

  always_comb begin
    status.all_done     = &done_r;
    status.np_exhausted = (np_h > {1'b0, n_m1});
    status.s_beyond     = (s > n_m1);
    status.s_taken      = has_r[s];
    status.cur_is_h     = (part_q == h_r);
    status.new_wins     = (rank_new_q_r <= rank_cur_q_r);
    status.emit_last    = (a_r == n_m1);
    status.out_free     = !out_valid_r || out_ready;
  end

  // Size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Proposer list store: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_prop) begin
      plist_mem_r[{in_data.row, in_data.position}] <= who;
    end
    if (cmd.propose) begin
      list_q_r <= plist_mem_r[{free_idx, np_h[IDX_W-1:0]}];
    end
  end

  // Acceptor rank store: one write and two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.wr_acc) begin
      rank_mem_r[{in_data.row, who}] <= in_data.position;
    end
    if (cmd.read_ranks) begin
      rank_new_q_r <= rank_mem_r[{s, h_r}];
      rank_cur_q_r <= rank_mem_r[{s, part_q}];
    end
  end

  // Proposer and partner bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.propose) begin
      h_r <= free_idx;
    end
    if (cmd.read_ranks) begin
      cur_r <= part_q;
    end
    if (cmd.accept_free || cmd.replace) begin
      partner_r[s] <= h_r;
    end
  end

  // Control-like matching state, cleared by reset and at the start of a run (unused parties then start done).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      has_r  <= '0;
      a_r    <= '0;
      for (int i = 0; i < MAX_PARTIES; i++) begin
        np_r[i] <= '0;
      end
    end else if (cmd.clear) begin
      has_r <= '0;
      a_r   <= '0;
      for (int i = 0; i < MAX_PARTIES; i++) begin
        done_r[i] <= (IDX_W'(i) > n_m1);
        np_r[i]   <= '0;
      end
    end else begin
      if (cmd.mark_done) begin
        done_r[free_idx] <= 1'b1;
      end
      if (cmd.propose) begin
        np_r[free_idx] <= np_h + POS_W'(1);
      end
      if (cmd.accept_free) begin
        has_r[s]    <= 1'b1;
        done_r[h_r] <= 1'b1;
      end
      if (cmd.replace) begin
        done_r[h_r]   <= 1'b1;
        done_r[cur_r] <= 1'b0;
      end
      if (cmd.emit) begin
        a_r <= a_r + IDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.acceptor <= a_r;
      out_data_r.matched  <= has_r[a_r];
      out_data_r.partner  <= has_r[a_r] ? part_q : '0;
      out_data_r.last     <= (a_r == n_m1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/smp_ctrl.sv =====
module smp_ctrl
  import smp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_action,
  input  smp_status_t status,
  output logic        in_ready,
  output smp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIND = 3'd1;
  localparam logic [2:0] ST_LIST = 3'd2;
  localparam logic [2:0] ST_RANK = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_action)
            ACT_LOAD_PROP: cmd.wr_prop = 1'b1;
            ACT_LOAD_ACC:  cmd.wr_acc  = 1'b1;
            ACT_RUN: begin
              cmd.clear = 1'b1;
              state_nxt = ST_FIND;
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        if (status.all_done) begin
          state_nxt = ST_OUT;
        end else if (status.np_exhausted) begin
          cmd.mark_done = 1'b1;
        end else begin
          cmd.propose = 1'b1;
          state_nxt   = ST_LIST;
        end
      end
      ST_LIST: begin
        state_nxt = ST_FIND;
        if (status.s_beyond) begin
          state_nxt = ST_FIND;
        end else if (!status.s_taken) begin
          cmd.accept_free = 1'b1;
        end else if (!status.cur_is_h) begin
          cmd.read_ranks = 1'b1;
          state_nxt      = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.replace = status.new_wins;
        state_nxt   = ST_FIND;
      end
      ST_OUT: begin
        cmd.report = 1'b1;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/stable_matching_proposer.sv =====
// Proposer-driven stable matching engine for up to 16 proposers and 16
// acceptors. Load transactions (one per cycle) write a proposer's list entry
// or an acceptor's preference, kept as a rank; a run transaction computes the
// matching and returns one result per acceptor in use, the final one flagged
// last. A run first clears the matching state, then handles each proposal as
// a free-proposer search followed by a registered list read, plus a
// registered read of both ranks when the target acceptor is taken by another
// proposer; a proposer whose list runs out is marked settled, and once every
// proposer is settled the results are emitted in order while the output is
// taken; at most n*n proposals occur for n parties. Proposals are handled
// one at a time through the list and rank memories. Input
// is taken only while no run is in progress; results can still wait in the
// output register while loads are taken. Write size only while idle.
module stable_matching_proposer
  import smp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  smp_cmd_t    cmd;
  smp_status_t status;

  smp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  smp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/smp_checker.sv =====
module smp_checker
  import smp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data
);

  logic [IDX_W-1:0] exp_acc_r;

  // Expected acceptor index of the next result transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_acc_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_acc_r <= out_data.last ? '0 : exp_acc_r + IDX_W'(1);
    end
  end

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed before it was taken");

  // Results report acceptors in order from zero.
  a_acc_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.acceptor == exp_acc_r)
    else $error("acceptor out of order");

  // An unmatched acceptor reports partner zero.
  a_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.matched |-> out_data.partner == '0)
    else $error("unmatched result carries a partner");

  // No input is taken while a run still has results to produce.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken in the middle of a run");

  // A run transaction always makes the block busy in the next cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_RUN |=> !in_ready)
    else $error("run did not start");

endmodule

bind stable_matching_proposer smp_checker u_smp_checker (.*);
